>>> sv/spq_pkg.sv
// spq_pkg: request, response and entry types for the sorted priority queue
// used by spq_cell and sorted_priority_queue; no dependencies
package spq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic [0:0] {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    func_t                    func;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRI_W-1:0]         item_priority;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [VALUE_W-1:0] out_value;
    logic [PRI_W-1:0]         out_priority;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  typedef struct packed {
    logic                     valid;
    logic signed [VALUE_W-1:0] value;
    logic [PRI_W-1:0]         priority_lvl;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic                     do_insert;
    logic                     do_extract;
    logic signed [VALUE_W-1:0] value;
    logic [PRI_W-1:0]         priority_lvl;
  } cell_ctrl_t;

  // per-cell comparison flags seen by the neighbours and the top level
  typedef struct packed {
    logic le;
    logic match;
    logic first;
  } cell_flags_t;

endpackage

>>> sv/sorted_priority_queue.sv
// sorted_priority_queue: top level, a chain of DEPTH spq_cell slots with a response register
// depends on spq_pkg and spq_cell
//
// Usage: one request channel (req_valid, req_ready, req) and one response
// channel (rsp_valid, rsp_ready, rsp). Every request gives exactly one response.
// An insert places the entry behind all held entries of equal or lower
// priority, or reports full. An extract removes the first entry of the given
// priority and returns it, or reports empty or not found.
// All cells compare against the request in the same cycle and shift towards
// or away from the head together, so the response appears in the response
// register on the next cycle, and the queue takes one request per cycle
// while the response side keeps taking.
// req_ready is high whenever the response register is empty or being taken
// in the same cycle; a stalled receiver holds the response and stops
// further requests until it is taken.
// Reset clears the valid bit of every cell and the entry count; the queue is
// empty straight after reset, with no clearing pass.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  spq_pkg::entry_t      entries [DEPTH];
  spq_pkg::cell_flags_t flags   [DEPTH];
  spq_pkg::cell_ctrl_t  ctrl;
  spq_pkg::rsp_t        rsp_next;
  spq_pkg::entry_t      hit;
  logic [DEPTH-1:0]     match_vec;
  logic [DEPTH-1:0]     valid_vec;
  logic [DEPTH-1:0]     first_vec;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_next;
  logic                 accept;
  logic                 found;
  logic                 full;
  logic                 rsp_valid_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (cnt == CNT_W'(DEPTH));
  assign found     = |match_vec;

  assign ctrl.do_insert    = accept && (req.func == spq_pkg::FUNC_INSERT) && !full;
  assign ctrl.do_extract   = accept && (req.func == spq_pkg::FUNC_EXTRACT) && found;
  assign ctrl.value        = req.item_value;
  assign ctrl.priority_lvl = req.item_priority;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t prev_entry;
    spq_pkg::entry_t next_entry;
    logic            prev_le;
    logic            prev_match;

    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_le    = 1'b1;
      assign prev_match = 1'b0;
    end else begin : g_body
      assign prev_entry = entries[i-1];
      assign prev_le    = flags[i-1].le;
      assign prev_match = flags[i-1].match;
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_entry (prev_entry),
      .prev_le    (prev_le),
      .prev_match (prev_match),
      .next_entry (next_entry),
      .entry      (entries[i]),
      .flags      (flags[i])
    );

    assign match_vec[i] = flags[i].match;
    assign valid_vec[i] = entries[i].valid;
    assign first_vec[i] = flags[i].first;
  end

  // one-hot select of the first matching entry
  always_comb begin
    hit = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        hit = hit | entries[i];
      end
    end
  end

  always_comb begin
    cnt_next              = cnt;
    rsp_next.status       = spq_pkg::STATUS_OK;
    rsp_next.out_value    = '0;
    rsp_next.out_priority = '0;
    if (req.func == spq_pkg::FUNC_INSERT) begin
      if (full) begin
        rsp_next.status = spq_pkg::STATUS_FULL;
      end else begin
        cnt_next = cnt + CNT_W'(1);
      end
    end else if (cnt == '0) begin
      rsp_next.status = spq_pkg::STATUS_EMPTY;
    end else if (!found) begin
      rsp_next.status = spq_pkg::STATUS_NOT_FOUND;
    end else begin
      rsp_next.out_value    = hit.value;
      rsp_next.out_priority = hit.priority_lvl;
      cnt_next              = cnt - CNT_W'(1);
    end
    rsp_next.occupancy = spq_pkg::OCC_W'(cnt_next);
  end

  assign rsp_valid_next = accept || (rsp_valid && !rsp_ready);

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
    if (rst) begin
      rsp_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      rsp_valid <= rsp_valid_next;
      if (accept) begin
        cnt <= cnt_next;
      end
    end
  end

  a_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_cnt_valid : assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(cnt))
    else $error("valid cells disagree with entry count");

  a_first_once : assert property (@(posedge clk) disable iff (rst)
    $onehot0(first_vec))
    else $error("more than one first match");

  a_extract_pri : assert property (@(posedge clk) disable iff (rst)
    (ctrl.do_extract) |=>
      (rsp.status == spq_pkg::STATUS_OK) && (rsp.out_priority == $past(req.item_priority)))
    else $error("extracted entry has wrong priority");

endmodule

>>> sv/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds an entry and shifts with its neighbours
// depends on spq_pkg
module spq_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  spq_pkg::cell_ctrl_t  ctrl,
  input  spq_pkg::entry_t      prev_entry,
  input  logic                 prev_le,
  input  logic                 prev_match,
  input  spq_pkg::entry_t      next_entry,
  output spq_pkg::entry_t      entry,
  output spq_pkg::cell_flags_t flags
);

  spq_pkg::entry_t entry_next;
  logic            ge;

  assign flags.le    = entry.valid && (entry.priority_lvl <= ctrl.priority_lvl);
  assign flags.match = entry.valid && (entry.priority_lvl == ctrl.priority_lvl);
  assign flags.first = flags.match && !prev_match;
  assign ge          = !entry.valid || (entry.priority_lvl >= ctrl.priority_lvl);

  always_comb begin
    entry_next = entry;
    if (ctrl.do_insert && !flags.le) begin
      if (prev_le) begin
        entry_next.valid        = 1'b1;
        entry_next.value        = ctrl.value;
        entry_next.priority_lvl = ctrl.priority_lvl;
      end else begin
        entry_next = prev_entry;
      end
    end else if (ctrl.do_extract && ge) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry.value        <= entry_next.value;
    entry.priority_lvl <= entry_next.priority_lvl;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench for sorted_priority_queue, a directed table then random
// requests, each response checked against its table entry or a sorted-list model held in the bench
// depends on spq_pkg and sorted_priority_queue
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned DEPTH       = 16;
  localparam int          N_RANDOM    = 1025;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          LONG_STALL  = 80;

  typedef struct {
    spq_pkg::req_t req;
    bit            typed;
    spq_pkg::rsp_t rsp;
  } dir_row_t;

  logic          clk;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  spq_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  spq_pkg::rsp_t rsp;

  // model of the held entries, head first
  logic signed [spq_pkg::VALUE_W-1:0] held_value [DEPTH];
  logic [spq_pkg::PRI_W-1:0]          held_prio  [DEPTH];
  int                                 held_count;

  spq_pkg::rsp_t pending_rsp [$];
  dir_row_t      dir_rows    [$];

  int cycle_count;
  int errors;
  int mismatches;
  int n_sent;
  int n_taken;
  int n_insert;
  int n_extract;
  int n_full;
  int n_empty;
  int n_missing;
  bit sender_done;

  sorted_priority_queue #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // applies one request to the model and returns the response it should give
  function automatic spq_pkg::rsp_t queue_apply(spq_pkg::req_t r);
    spq_pkg::rsp_t o;
    int            pos;
    int            i;
    o = '0;
    o.status = spq_pkg::STATUS_OK;
    pos = 0;
    if (r.func == spq_pkg::FUNC_INSERT) begin
      n_insert++;
      if (held_count >= DEPTH) begin
        o.status = spq_pkg::STATUS_FULL;
        n_full++;
      end else begin
        while (pos < held_count && held_prio[pos] <= r.item_priority) pos++;
        for (i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[pos] = r.item_value;
        held_prio[pos]  = r.item_priority;
        held_count++;
      end
    end else begin
      n_extract++;
      if (held_count == 0) begin
        o.status = spq_pkg::STATUS_EMPTY;
        n_empty++;
      end else begin
        while (pos < held_count && held_prio[pos] != r.item_priority) pos++;
        if (pos >= held_count) begin
          o.status = spq_pkg::STATUS_NOT_FOUND;
          n_missing++;
        end else begin
          o.out_value    = held_value[pos];
          o.out_priority = held_prio[pos];
          for (i = pos; i + 1 < held_count; i++) begin
            held_value[i] = held_value[i+1];
            held_prio[i]  = held_prio[i+1];
          end
          held_count--;
        end
      end
    end
    o.occupancy = spq_pkg::OCC_W'(held_count);
    return o;
  endfunction

  function automatic logic [spq_pkg::PRI_W-1:0] rand_priority();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return spq_pkg::PRI_W'($urandom_range(0, 7));
    if (sel < 60) return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    return spq_pkg::PRI_W'($urandom);
  endfunction

  function automatic void add_row(spq_pkg::func_t f, logic [31:0] v, logic [7:0] p,
                                  bit typed, spq_pkg::status_t s, logic [31:0] ov,
                                  logic [7:0] op, logic [4:0] occ);
    dir_row_t row;
    row.req.func          = f;
    row.req.item_value    = v;
    row.req.item_priority = p;
    row.typed             = typed;
    row.rsp.status        = s;
    row.rsp.out_value     = ov;
    row.rsp.out_priority  = op;
    row.rsp.occupancy     = occ;
    dir_rows.push_back(row);
  endfunction

  // drives one request and waits for it to be taken; called at a falling edge
  task automatic send_request(spq_pkg::req_t r, bit typed, spq_pkg::rsp_t typed_rsp,
                              int gap);
    spq_pkg::rsp_t predicted;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    predicted = queue_apply(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    n_sent++;
    @(negedge clk);
  endtask

  // sender: directed table, then random requests
  initial begin
    spq_pkg::req_t r;
    spq_pkg::rsp_t none;
    int            gap;
    int            mode;
    int            ins_pct;
    dir_row_t      row;
    none = '0;
    held_count = 0;
    add_row(spq_pkg::FUNC_EXTRACT, 32'h0000_0000, 8'd0,   1, spq_pkg::STATUS_EMPTY,
            32'h0, 8'd0, 5'd0);
    add_row(spq_pkg::FUNC_INSERT,  32'h7fff_ffff, 8'd255, 1, spq_pkg::STATUS_OK,
            32'h0, 8'd0, 5'd1);
    add_row(spq_pkg::FUNC_INSERT,  32'h8000_0000, 8'd0,   1, spq_pkg::STATUS_OK,
            32'h0, 8'd0, 5'd2);
    add_row(spq_pkg::FUNC_INSERT,  32'hffff_ffff, 8'd255, 1, spq_pkg::STATUS_OK,
            32'h0, 8'd0, 5'd3);
    add_row(spq_pkg::FUNC_EXTRACT, 32'h0000_0000, 8'd7,   1, spq_pkg::STATUS_NOT_FOUND,
            32'h0, 8'd0, 5'd3);
    add_row(spq_pkg::FUNC_EXTRACT, 32'h0000_0000, 8'd255, 1, spq_pkg::STATUS_OK,
            32'h7fff_ffff, 8'd255, 5'd2);
    add_row(spq_pkg::FUNC_EXTRACT, 32'hffff_ffff, 8'd0,   1, spq_pkg::STATUS_OK,
            32'h8000_0000, 8'd0, 5'd1);
    add_row(spq_pkg::FUNC_INSERT, 32'h5555_5555, 8'd1,   0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'haaaa_aaaa, 8'd200, 0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'h0000_0001, 8'd1,   0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'h8000_0001, 8'd128, 0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'h1234_5678, 8'd0,   0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'hdead_beef, 8'd2,   0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'h0f0f_0f0f, 8'd1,   0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'hf0f0_f0f0, 8'd64,  0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'h0000_0000, 8'd255, 0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'h7fff_fffe, 8'd3,   0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'h3333_cccc, 8'd100, 0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'hcccc_3333, 8'd1,   0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'h0000_ffff, 8'd254, 0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'hffff_0000, 8'd5,   0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT, 32'h0101_0101, 8'd0,   0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_INSERT,  32'h0000_1234, 8'd1,   1, spq_pkg::STATUS_FULL,
            32'h0, 8'd0, 5'd16);
    add_row(spq_pkg::FUNC_EXTRACT, 32'h0000_0000, 8'd1,   0, spq_pkg::STATUS_OK, 0, 0, 0);
    add_row(spq_pkg::FUNC_EXTRACT, 32'h0000_0000, 8'd255, 0, spq_pkg::STATUS_OK, 0, 0, 0);

    wait (rst == 1'b0);
    @(negedge clk);
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      send_request(row.req, row.typed, row.rsp, $urandom_range(0, 5));
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // occupancy is steered by phases that favour inserts or extracts
      mode = (n / 64) % 4;
      ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : (mode == 2) ? 50 : 60;
      r.item_value = spq_pkg::VALUE_W'($urandom);
      if ($urandom_range(0, 99) < ins_pct) begin
        r.func          = spq_pkg::FUNC_INSERT;
        r.item_priority = rand_priority();
      end else begin
        r.func = spq_pkg::FUNC_EXTRACT;
        if (held_count > 0 && $urandom_range(0, 99) < 80)
          r.item_priority = held_prio[$urandom_range(0, held_count - 1)];
        else
          r.item_priority = rand_priority();
      end
      gap = ((n % 200) < 40) ? 0 : $urandom_range(0, 5);
      send_request(r, 1'b0, none, gap);
    end
    req_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // receiver: random stalls, a long hold-off twice, responses checked in order
  initial begin
    int            stall;
    spq_pkg::rsp_t got;
    spq_pkg::rsp_t want;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (n_taken == 300 || n_taken == 700)
        stall = LONG_STALL;
      else if ((n_taken % 200) < 40)
        stall = 0;
      else
        stall = $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      got = rsp;
      @(negedge clk);
      n_taken++;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected response: status %0d value %h priority %0d occupancy %0d",
                   got.status, got.out_value, got.out_priority, got.occupancy);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status || got.out_value !== want.out_value ||
            got.out_priority !== want.out_priority || got.occupancy !== want.occupancy) begin
          errors++;
          if (mismatches < 10)
            $display({"response %0d mismatch (expected/actual): status %0d/%0d ",
                      "value %h/%h priority %0d/%0d occupancy %0d/%0d"},
                     n_taken, want.status, got.status, want.out_value, got.out_value,
                     want.out_priority, got.out_priority, want.occupancy, got.occupancy);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
             pending_rsp.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (sender_done);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_rsp.size() != 0) errors += pending_rsp.size();
    $display("%0d requests (%0d inserts, %0d extracts), %0d responses checked",
             n_sent, n_insert, n_extract, n_taken);
    $display("full %0d, empty %0d, priority not found %0d, mismatches %0d",
             n_full, n_empty, n_missing, mismatches);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
